// ===== design/assert_macros.svh =====
// Assertion macros for the packet buffer slot manager.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset.
`define PBSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PBSM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define PBSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pbsm_pkg.sv =====
// Shared types and constants of the packet buffer slot manager.
// Used by pbsm_core, pbsm_out_buf and packet_buffer_slot_manager; no dependencies.
package pbsm_pkg;

    // Pool size; slot fields are 4 bits wide, so the pool is fixed at 16 slots
    localparam int SLOTS       = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int LEN_W       = 16;
    localparam int DISCARD_W   = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1500;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERSIZE = 2'd1,
        STATUS_REFUSED  = 2'd2
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [SLOT_W-1:0]      slot;
        logic [LEN_W-1:0]       length;
        logic [LEN_W-1:0]       excess;
        logic                   dropped;
        logic [DISCARD_W-1:0]   discards;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] ready_count;
    } occupancy_t;

endpackage

// ===== design/pbsm_core.sv =====
// Slot bookkeeping: free list, ready queue, stored lengths, owners and discard counter.
// Depends on pbsm_pkg for types and sizes.
module pbsm_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pbsm_pkg::LEN_W-1:0]    cfg_wdata,
    input  logic                          accept,
    input  pbsm_pkg::cmd_t                cmd,
    input  logic [pbsm_pkg::LEN_W-1:0]    packet_length,
    input  logic [pbsm_pkg::SLOT_W-1:0]   slot_in,
    output pbsm_pkg::result_t             result,
    output pbsm_pkg::occupancy_t          occupancy
);

    typedef enum logic [1:0] {
        OWN_FREE   = 2'd0,
        OWN_QUEUED = 2'd1,
        OWN_HELD   = 2'd2
    } owner_t;

    logic [pbsm_pkg::LEN_W-1:0]     max_len_reg;
    logic [pbsm_pkg::SLOT_W-1:0]    free_slots_reg [pbsm_pkg::SLOTS];
    logic [pbsm_pkg::SLOT_W-1:0]    ready_slots_reg [pbsm_pkg::SLOTS];
    logic [pbsm_pkg::LEN_W-1:0]     slot_lengths_reg [pbsm_pkg::SLOTS];
    owner_t                         owner_reg [pbsm_pkg::SLOTS];

    logic [pbsm_pkg::SLOT_W-1:0]    free_head_reg, free_head_next;
    logic [pbsm_pkg::CNT_W-1:0]     free_count_reg, free_count_next;
    logic [pbsm_pkg::SLOT_W-1:0]    ready_head_reg, ready_head_next;
    logic [pbsm_pkg::CNT_W-1:0]     ready_count_reg, ready_count_next;
    logic [pbsm_pkg::DISCARD_W-1:0] discard_total_reg, discard_total_next;

    logic [pbsm_pkg::SLOT_W-1:0]    free_top, ready_top, free_tail, ready_tail;
    logic                           oversize, count_discard;
    logic                           free_we, ready_we, owner_we;
    logic [pbsm_pkg::SLOT_W-1:0]    free_wd, ready_wd, owner_wa;
    owner_t                         owner_wd;

    // Peek at both queue heads; ring indexes wrap naturally since SLOTS is a power of two
    assign free_top   = free_slots_reg[free_head_reg];
    assign ready_top  = ready_slots_reg[ready_head_reg];
    assign free_tail  = free_head_reg + free_count_reg[pbsm_pkg::SLOT_W-1:0];
    assign ready_tail = ready_head_reg + ready_count_reg[pbsm_pkg::SLOT_W-1:0];
    assign oversize   = packet_length > max_len_reg;

    assign occupancy.free_count  = free_count_reg;
    assign occupancy.ready_count = ready_count_reg;

    // Decode the command into pointer updates, array writes and the result
    always_comb
    begin
        free_head_next   = free_head_reg;
        free_count_next  = free_count_reg;
        ready_head_next  = ready_head_reg;
        ready_count_next = ready_count_reg;
        count_discard    = 1'b0;
        free_we          = 1'b0;
        free_wd          = slot_in;
        ready_we         = 1'b0;
        ready_wd         = free_top;
        owner_we         = 1'b0;
        owner_wa         = slot_in;
        owner_wd         = OWN_FREE;
        result.status    = pbsm_pkg::STATUS_REFUSED;
        result.slot      = '0;
        result.length    = '0;
        result.excess    = '0;
        result.dropped   = 1'b0;

        case (cmd)
            pbsm_pkg::CMD_ADD:
            begin
                if (oversize)
                begin
                    result.status = pbsm_pkg::STATUS_OVERSIZE;
                    result.excess = packet_length - max_len_reg;
                    count_discard = 1'b1;
                end
                else if (free_count_reg != '0)
                begin
                    result.status    = pbsm_pkg::STATUS_OK;
                    result.slot      = free_top;
                    free_head_next   = free_head_reg + 1'b1;
                    free_count_next  = free_count_reg - 1'b1;
                    ready_count_next = ready_count_reg + 1'b1;
                    ready_we         = 1'b1;
                    ready_wd         = free_top;
                end
                else
                begin
                    count_discard = 1'b1;
                    // Reuse the oldest queued slot: pop then push, count unchanged
                    if (ready_count_reg != '0)
                    begin
                        result.status   = pbsm_pkg::STATUS_OK;
                        result.slot     = ready_top;
                        result.dropped  = 1'b1;
                        ready_head_next = ready_head_reg + 1'b1;
                        ready_we        = 1'b1;
                        ready_wd        = ready_top;
                    end
                end
                owner_wa = ready_wd;
                owner_wd = OWN_QUEUED;
                owner_we = ready_we;
            end
            pbsm_pkg::CMD_GET:
            begin
                if (ready_count_reg != '0)
                begin
                    result.status    = pbsm_pkg::STATUS_OK;
                    result.slot      = ready_top;
                    result.length    = slot_lengths_reg[ready_top];
                    ready_head_next  = ready_head_reg + 1'b1;
                    ready_count_next = ready_count_reg - 1'b1;
                    owner_we         = 1'b1;
                    owner_wa         = ready_top;
                    owner_wd         = OWN_HELD;
                end
            end
            pbsm_pkg::CMD_REMOVE:
            begin
                if (owner_reg[slot_in] == OWN_HELD)
                begin
                    result.status   = pbsm_pkg::STATUS_OK;
                    free_we         = 1'b1;
                    free_count_next = free_count_reg + 1'b1;
                    owner_we        = 1'b1;
                    owner_wa        = slot_in;
                    owner_wd        = OWN_FREE;
                end
            end
            default:
            begin
            end
        endcase

        // Saturate the discard counter at its top value
        if (count_discard && (discard_total_reg != '1))
            discard_total_next = discard_total_reg + 1'b1;
        else
            discard_total_next = discard_total_reg;
        result.discards = discard_total_next;
    end

    // Advance control state, free list and owners on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg       <= pbsm_pkg::MAX_LEN_RESET;
            free_head_reg     <= '0;
            free_count_reg    <= pbsm_pkg::CNT_W'(pbsm_pkg::SLOTS);
            ready_head_reg    <= '0;
            ready_count_reg   <= '0;
            discard_total_reg <= '0;
            for (int i = 0; i < pbsm_pkg::SLOTS; i++)
            begin
                free_slots_reg[i] <= pbsm_pkg::SLOT_W'(i);
                owner_reg[i]      <= OWN_FREE;
            end
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_wdata;
            if (accept)
            begin
                free_head_reg     <= free_head_next;
                free_count_reg    <= free_count_next;
                ready_head_reg    <= ready_head_next;
                ready_count_reg   <= ready_count_next;
                discard_total_reg <= discard_total_next;
                if (free_we)
                    free_slots_reg[free_tail] <= free_wd;
                if (owner_we)
                    owner_reg[owner_wa] <= owner_wd;
            end
        end
    end

    // Write ready queue entries and stored lengths; never read before written
    always_ff @(posedge clk)
    begin
        if (accept && ready_we)
        begin
            ready_slots_reg[ready_tail] <= ready_wd;
            slot_lengths_reg[ready_wd]  <= packet_length;
        end
    end

endmodule

// ===== design/pbsm_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on pbsm_pkg for the result type.
module pbsm_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pbsm_pkg::result_t in_item,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pbsm_pkg::result_t out_item
);

    logic              out_valid_reg, skid_valid_reg;
    pbsm_pkg::result_t out_item_reg, skid_item_reg;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Track which entries hold an item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    // Move payloads: refill output from skid first, park new items in skid on stall
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
                out_item_reg <= skid_item_reg;
            else if (push)
                out_item_reg <= in_item;
        end
        else if (push)
            skid_item_reg <= in_item;
    end

endmodule

// ===== design/packet_buffer_slot_manager.sv =====
// Top level of the packet buffer slot manager.
// Depends on pbsm_pkg, pbsm_core, pbsm_out_buf and assert_macros.svh.
//
// Usage:
//   A pool of 16 buffer slots is handed out through an input stream of
//   commands (add, get, remove, no-op) and answered by one result item per
//   command on the output stream. Packet bytes live outside, addressed by
//   slot number. max_packet_length is written through cfg_we/cfg_wdata.
//   Throughput: one command per cycle while s_tready is high. The whole decision (free list pop,
//   ready queue pop/push, length lookup, counter update) is one pass of
//   logic at the accept edge, so each item sees the state left by the
//   previous one without a bubble.
//   Output: the result of an accepted command is registered in the output
//   register, or in the skid register while the output stalls.
//   Reset: all 16 slots sit on the free list in order, the ready queue is
//   empty, the discard counter is zero and max_packet_length is 1500.
//   Stall: results wait in a two-entry buffer (output register plus skid);
//   s_tready drops only when both entries hold items, and rises again the
//   cycle after the receiver takes one.
`include "assert_macros.svh"

module packet_buffer_slot_manager (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pbsm_pkg::LEN_W-1:0]         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // packet_length [15:0], slot_in [19:16], zero [23:20]
    input  logic [pbsm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // cmd [1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // slot_out [3:0], length_out [19:4], excess [35:20], dropped_oldest [36],
    // discards [68:37], zero [71:69]
    output logic [pbsm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // status [1:0]
    output logic [1:0]                         m_tuser
);

    logic                 accept;
    pbsm_pkg::cmd_t       cmd;
    pbsm_pkg::result_t    result, out_item;
    pbsm_pkg::occupancy_t occupancy;

    assign accept = s_tvalid && s_tready;
    assign cmd    = pbsm_pkg::cmd_t'(s_tuser);

    // Decide each command against the slot state
    pbsm_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .accept        (accept),
        .cmd           (cmd),
        .packet_length (s_tdata[15:0]),
        .slot_in       (s_tdata[19:16]),
        .result        (result),
        .occupancy     (occupancy)
    );

    // Hold results until the receiver takes them
    pbsm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .in_item   (result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Pack the result item onto the output stream
    assign m_tdata = {3'b000, out_item.discards, out_item.dropped, out_item.excess,
                      out_item.length, out_item.slot};
    assign m_tuser = out_item.status;

    // Slots are never counted twice between the free list and the ready queue
    `PBSM_ASSERT(a_occupancy_bound, (pbsm_pkg::CNT_W+1)'(occupancy.free_count) + (pbsm_pkg::CNT_W+1)'(occupancy.ready_count) <= (pbsm_pkg::CNT_W+1)'(pbsm_pkg::SLOTS), "free and ready counts exceed the pool")

    // Reuse of the oldest packet happens only with an empty free list
    `PBSM_ASSERT_IMPL(a_drop_needs_empty, accept && result.dropped, occupancy.free_count == '0, "oldest packet dropped while a slot was free")

    // A successful get shrinks the ready queue by one
    `PBSM_ASSERT_NEXT(a_get_pops, accept && (cmd == pbsm_pkg::CMD_GET) && (occupancy.ready_count != '0), occupancy.ready_count == pbsm_pkg::CNT_W'($past(occupancy.ready_count) - 1'b1), "get did not pop the ready queue")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for packet_buffer_slot_manager: command stream in, one reply per item.
// A clocked driver and monitor surround the block; an in-bench slot pool model predicts replies.
// Depends on pbsm_pkg and the packet_buffer_slot_manager RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 1000;

    typedef enum logic [1:0] {
        SLOT_FREE,
        SLOT_QUEUED,
        SLOT_HELD
    } slot_owner_t;

    typedef struct {
        pbsm_pkg::cmd_t op;
        logic [15:0]    len;
        logic [3:0]     slot;
    } slot_cmd_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [pbsm_pkg::LEN_W-1:0]       cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [pbsm_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]                       s_tuser = pbsm_pkg::CMD_NOP;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [pbsm_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]                       m_tuser;

    // Pool model state
    logic [3:0]        free_ring [pbsm_pkg::SLOTS];
    logic [3:0]        free_rd;
    logic [4:0]        free_cnt;
    logic [3:0]        ready_ring [pbsm_pkg::SLOTS];
    logic [3:0]        ready_rd;
    logic [4:0]        ready_cnt;
    logic [15:0]       stored_len [pbsm_pkg::SLOTS];
    slot_owner_t       owner [pbsm_pkg::SLOTS];
    logic [31:0]       discard_total;
    logic [15:0]       limit_len;

    slot_cmd_t           cmd_backlog [$];
    pbsm_pkg::result_t   reply_due [$];
    pbsm_pkg::result_t   reply_want;
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         error_count = 0;
    int unsigned         quiet_cycles = 0;

    packet_buffer_slot_manager DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one command to the pool model and return the reply it yields
    function automatic pbsm_pkg::result_t run_slot_command(pbsm_pkg::cmd_t op,
                                                           logic [15:0] len,
                                                           logic [3:0] sin);
        pbsm_pkg::result_t r;
        logic [3:0]        s;
        logic [3:0]        idx;
        r = '0;
        r.status = pbsm_pkg::STATUS_REFUSED;
        case (op)
            pbsm_pkg::CMD_ADD:
            begin
                if (len > limit_len)
                begin
                    r.status = pbsm_pkg::STATUS_OVERSIZE;
                    r.excess = len - limit_len;
                    if (discard_total != '1)
                        discard_total++;
                end
                else
                begin
                    if (free_cnt != 0)
                    begin
                        s = free_ring[free_rd];
                        free_rd++;
                        free_cnt--;
                    end
                    else
                    begin
                        if (discard_total != '1)
                            discard_total++;
                        s = ready_ring[ready_rd];
                        if (ready_cnt != 0)
                        begin
                            ready_rd++;
                            ready_cnt--;
                            r.dropped = 1'b1;
                        end
                    end
                    // queue the slot unless everything is held by the consumer
                    if (r.dropped || (owner[s] == SLOT_FREE))
                    begin
                        idx = ready_rd + ready_cnt[3:0];
                        ready_ring[idx] = s;
                        ready_cnt++;
                        stored_len[s] = len;
                        owner[s] = SLOT_QUEUED;
                        r.slot = s;
                        r.status = pbsm_pkg::STATUS_OK;
                    end
                end
            end
            pbsm_pkg::CMD_GET:
            begin
                if (ready_cnt != 0)
                begin
                    s = ready_ring[ready_rd];
                    ready_rd++;
                    ready_cnt--;
                    owner[s] = SLOT_HELD;
                    r.slot = s;
                    r.length = stored_len[s];
                    r.status = pbsm_pkg::STATUS_OK;
                end
            end
            pbsm_pkg::CMD_REMOVE:
            begin
                if (owner[sin] == SLOT_HELD)
                begin
                    idx = free_rd + free_cnt[3:0];
                    free_ring[idx] = sin;
                    free_cnt++;
                    owner[sin] = SLOT_FREE;
                    r.status = pbsm_pkg::STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
        r.discards = discard_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic queue_cmd(input pbsm_pkg::cmd_t op, input logic [15:0] len,
                             input logic [3:0] sin);
        cmd_backlog.push_back('{op, len, sin});
    endtask

    // Wait until every item is sent and every reply has come back
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || s_tvalid || reply_due.size() != 0)
            @(negedge clk);
    endtask

    // Lengths around the limit, at the field extremes, and at random
    function automatic logic [15:0] pick_length(logic [15:0] lim);
        case ($urandom_range(9))
            0: return 16'd0;
            1: return lim;
            2: return (lim == 16'hFFFF) ? lim : lim + 16'd1;
            3: return 16'hFFFF;
            8, 9: return 16'($urandom);
            default: return 16'($urandom_range(lim));
        endcase
    endfunction

    // Build random bursts for one configuration phase
    task automatic fill_phase(input int unsigned quota);
        int unsigned counted;
        int unsigned pick;
        int          order [pbsm_pkg::SLOTS];
        int          j;
        int          tmp;
        counted = 0;
        while (counted < quota)
        begin
            pick = $urandom_range(9);
            if (pick <= 1)
            begin
                // fill the pool past full, take everything, add into an all-held pool, free all
                repeat (20)
                    queue_cmd(pbsm_pkg::CMD_ADD, 16'($urandom_range(limit_len)), 4'($urandom));
                repeat (20) queue_cmd(pbsm_pkg::CMD_GET, 16'($urandom), 4'($urandom));
                repeat (4)
                    queue_cmd(pbsm_pkg::CMD_ADD, 16'($urandom_range(limit_len)), 4'($urandom));
                for (int i = 0; i < pbsm_pkg::SLOTS; i++)
                    order[i] = i;
                for (int i = pbsm_pkg::SLOTS - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < pbsm_pkg::SLOTS; i++)
                    queue_cmd(pbsm_pkg::CMD_REMOVE, 16'($urandom), 4'(order[i]));
                counted += 60;
            end
            else if (pick <= 8)
            begin
                // mixed traffic with lengths around the limit
                repeat (24)
                begin
                    tmp = $urandom_range(99);
                    if (tmp < 40)
                        queue_cmd(pbsm_pkg::CMD_ADD, pick_length(limit_len), 4'($urandom));
                    else if (tmp < 70)
                        queue_cmd(pbsm_pkg::CMD_GET, 16'($urandom), 4'($urandom));
                    else if (tmp < 95)
                        queue_cmd(pbsm_pkg::CMD_REMOVE, 16'($urandom), 4'($urandom));
                    else
                        queue_cmd(pbsm_pkg::CMD_NOP, 16'($urandom), 4'($urandom));
                end
                counted += 24;
            end
            else
            begin
                // noise: no-ops and stray removes
                repeat (8)
                    queue_cmd(pbsm_pkg::cmd_t'($urandom_range(3, 2)), 16'($urandom),
                              4'($urandom));
                counted += 8;
            end
        end
    endtask

    // Driver: present the oldest pending command, predict its reply on accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= pbsm_pkg::CMD_NOP;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reply_due.push_back(run_slot_command(cmd_backlog[0].op, cmd_backlog[0].len,
                                                     cmd_backlog[0].slot));
                void'(cmd_backlog.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, cmd_backlog[0].slot, cmd_backlog[0].len};
                    s_tuser  <= cmd_backlog[0].op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, check each reply, watch for a hang
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready)
            begin
                if (reply_due.size() == 0)
                    report_mismatch("unexpected reply, status", 32'(m_tuser),
                                    32'(pbsm_pkg::STATUS_OK));
                else
                begin
                    reply_want = reply_due.pop_front();
                    if (m_tuser !== reply_want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(reply_want.status));
                    if (m_tdata[3:0] !== reply_want.slot)
                        report_mismatch("slot_out", 32'(m_tdata[3:0]), 32'(reply_want.slot));
                    if (m_tdata[19:4] !== reply_want.length)
                        report_mismatch("length_out", 32'(m_tdata[19:4]), 32'(reply_want.length));
                    if (m_tdata[35:20] !== reply_want.excess)
                        report_mismatch("excess", 32'(m_tdata[35:20]), 32'(reply_want.excess));
                    if (m_tdata[36] !== reply_want.dropped)
                        report_mismatch("dropped_oldest", 32'(m_tdata[36]),
                                        32'(reply_want.dropped));
                    if (m_tdata[68:37] !== reply_want.discards)
                        report_mismatch("discards", m_tdata[68:37], reply_want.discards);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
                $display("** packet_buffer_slot_manager: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus and run control
    initial
    begin
        // pool model reset: every slot free, in order
        for (int i = 0; i < pbsm_pkg::SLOTS; i++)
        begin
            free_ring[i] = 4'(i);
            ready_ring[i] = '0;
            stored_len[i] = '0;
            owner[i] = SLOT_FREE;
        end
        free_rd = '0;
        free_cnt = 5'(pbsm_pkg::SLOTS);
        ready_rd = '0;
        ready_cnt = '0;
        discard_total = '0;
        limit_len = pbsm_pkg::MAX_LEN_RESET;

        send_idle_pct = 10;
        recv_idle_pct = 52;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty queue, stray removes, no-op, limit edges, get and free, overflow
        queue_cmd(pbsm_pkg::CMD_GET, 16'hFFFF, 4'hF);
        queue_cmd(pbsm_pkg::CMD_REMOVE, 16'h0000, 4'd15);
        queue_cmd(pbsm_pkg::CMD_NOP, 16'hFFFF, 4'hF);
        queue_cmd(pbsm_pkg::CMD_ADD, 16'd0, 4'd0);
        queue_cmd(pbsm_pkg::CMD_ADD, 16'd1500, 4'd0);
        queue_cmd(pbsm_pkg::CMD_ADD, 16'd1501, 4'd0);
        queue_cmd(pbsm_pkg::CMD_ADD, 16'hFFFF, 4'd0);
        queue_cmd(pbsm_pkg::CMD_REMOVE, 16'd0, 4'd1);
        queue_cmd(pbsm_pkg::CMD_GET, 16'd0, 4'd0);
        queue_cmd(pbsm_pkg::CMD_REMOVE, 16'd0, 4'd0);
        queue_cmd(pbsm_pkg::CMD_GET, 16'd0, 4'd0);
        repeat (16) queue_cmd(pbsm_pkg::CMD_ADD, 16'($urandom_range(1500)), 4'($urandom));
        wait_drained();

        // random phases, each with its own length limit; the idle pattern changes every two phases
        for (int p = 0; p < 6; p++)
        begin
            @(negedge clk);
            send_idle_pct = (p < 2) ? 10 : (p < 4) ? 52 : 0;
            recv_idle_pct = (p < 2) ? 52 : (p < 4) ? 10 : 0;
            limit_len = (p == 0) ? 16'd1 :
                        (p == 1) ? 16'hFFFF :
                        (p == 3) ? 16'd1500 : 16'($urandom_range(65534, 2));
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= limit_len;
            @(posedge clk);
            cfg_we    <= 1'b0;
            @(negedge clk);
            fill_phase(195);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("** packet_buffer_slot_manager: PASSED **");
        else
            $display("** packet_buffer_slot_manager: FAILED **");
        $finish;
    end

endmodule
